[rtl/core/rgbyp_pkg.sv]
package rgbyp_pkg;

    // Field and arithmetic widths
    localparam int CHANNEL_BITS  = 16;
    localparam int FRACTION_BITS = 15;
    localparam int COEF_BITS     = 16;
    localparam int LANES         = 3;

    // Quotient bits of the normalizing divide: fraction reaches 1.0 = 2^F
    localparam int DIV_STEPS = FRACTION_BITS + 1;
    localparam int DIV_W     = CHANNEL_BITS + DIV_STEPS;

    // Matrix arithmetic
    localparam int X_BITS    = CHANNEL_BITS + 1;
    localparam int K_BITS    = 18;
    localparam int PROD_BITS = X_BITS + K_BITS;
    localparam int SUM_BITS  = PROD_BITS + 2;

    // Inverse scaling: fraction in Q.(F+16) times full scale
    localparam int INV_SHIFT     = FRACTION_BITS + COEF_BITS;
    localparam int INV_PROD_BITS = INV_SHIFT + CHANNEL_BITS;

    localparam logic [CHANNEL_BITS-1:0] SCALE_RESET = CHANNEL_BITS'(255);

    // Conversion direction codes
    localparam logic KIND_FWD = 1'b0;
    localparam logic KIND_INV = 1'b1;

    // Q.16 matrices, [kind][row][col]
    // forward: rows Y, Pb, Pr over cols R, G, B
    // inverse: rows R, G, B over cols Y, Pb, Pr
    localparam logic signed [K_BITS-1:0] COEF [2][3][3] = '{
        '{ '{ 19595,  38470,   7471},
           '{-11058, -21710,  32768},
           '{ 32768, -27439,  -5329} },
        '{ '{ 65536,      0,  91881},
           '{ 65536, -22553, -46802},
           '{ 65536, 116130,      0} }
    };

    typedef struct packed {
        logic                           kind;
        logic        [CHANNEL_BITS-1:0] red;
        logic        [CHANNEL_BITS-1:0] green;
        logic        [CHANNEL_BITS-1:0] blue;
        logic        [CHANNEL_BITS-1:0] luma;
        logic signed [CHANNEL_BITS-1:0] blue_diff;
        logic signed [CHANNEL_BITS-1:0] red_diff;
    } pix_in_t;

    typedef struct packed {
        logic        [CHANNEL_BITS-1:0] luma_out;
        logic signed [CHANNEL_BITS-1:0] blue_diff_out;
        logic signed [CHANNEL_BITS-1:0] red_diff_out;
        logic        [CHANNEL_BITS-1:0] red_out;
        logic        [CHANNEL_BITS-1:0] green_out;
        logic        [CHANNEL_BITS-1:0] blue_out;
    } pix_out_t;

    // One beat inside the divider: partial remainder over quotient bits,
    // or the raw inverse inputs in the low half
    typedef struct packed {
        logic                         kind;
        logic [LANES-1:0][DIV_W-1:0] w;
    } div_beat_t;

endpackage

[rtl/core/rgb_ypbpr_color_convert.sv]
// Channel  Signals                          Direction  Beat
// src      src_valid, src_stall, src_data   in         one pixel and its direction
// dst      dst_valid, dst_stall, dst_data   out        one converted pixel
// cfg      cfg_wen, cfg_wdata               in         full-scale RGB value
//
// One beat per clock while no result is held at the output by dst_stall.
// A beat passes the entry register, the 16 one-bit divide stages, then the product,
// row sum, range split, inverse scaling and output registers.
// rst_n clears all valid bits and loads a full scale of 255.
// A stalled result in the output register freezes the whole pipeline and
// raises src_stall in the same cycle; nothing is dropped or repeated.
module rgb_ypbpr_color_convert (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               src_valid,
    output logic                               src_stall,
    input  rgbyp_pkg::pix_in_t                 src_data,
    output logic                               dst_valid,
    input  logic                               dst_stall,
    output rgbyp_pkg::pix_out_t                dst_data,
    input  logic                               cfg_wen,
    input  logic [rgbyp_pkg::CHANNEL_BITS-1:0] cfg_wdata
);
    import rgbyp_pkg::*;

    localparam logic signed [SUM_BITS-1:0] FWD_HALF = SUM_BITS'(1) <<< (COEF_BITS - 1);
    localparam logic [INV_PROD_BITS:0]     INV_HALF = (INV_PROD_BITS + 1)'(1) << (INV_SHIFT - 1);

    logic adv;

    // Full-scale register, zero taken as one
    logic [CHANNEL_BITS-1:0] scale_reg;
    logic [CHANNEL_BITS-1:0] scale_next;

    assign scale_next = (cfg_wdata == '0) ? CHANNEL_BITS'(1) : cfg_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_wen)
        begin
            scale_reg <= scale_next;
        end
    end

    // Whole pipeline moves unless a result is held at the output
    logic dst_valid_reg;

    assign adv       = !(dst_valid_reg && dst_stall);
    assign src_stall = !adv;
    assign dst_valid = dst_valid_reg;

    // Entry stage: forward saturate and build dividend (c << F) + m/2, inverse raw
    logic                    in_valid_reg;
    div_beat_t               in_beat_reg;
    div_beat_t               in_beat_next;
    logic [CHANNEL_BITS-1:0] chan [LANES];
    logic [CHANNEL_BITS-1:0] raw  [LANES];
    logic [CHANNEL_BITS-1:0] sat  [LANES];

    always_comb
    begin
        chan[0] = src_data.red;
        chan[1] = src_data.green;
        chan[2] = src_data.blue;
        raw[0]  = src_data.luma;
        raw[1]  = src_data.blue_diff;
        raw[2]  = src_data.red_diff;
        in_beat_next.kind = src_data.kind;
        for (int l = 0; l < LANES; l++)
        begin
            sat[l] = (chan[l] > scale_reg) ? scale_reg : chan[l];
            if (src_data.kind == KIND_FWD)
            begin
                in_beat_next.w[l] = (DIV_W'(sat[l]) << FRACTION_BITS)
                                  + DIV_W'(scale_reg >> 1);
            end
            else
            begin
                in_beat_next.w[l] = DIV_W'(raw[l]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg <= src_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            in_beat_reg <= in_beat_next;
        end
    end

    // Divider chain, one quotient bit per stage
    logic      div_valid [DIV_STEPS+1];
    div_beat_t div_beat  [DIV_STEPS+1];

    assign div_valid[0] = in_valid_reg;
    assign div_beat[0]  = in_beat_reg;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        rgbyp_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .scale     (scale_reg),
            .in_valid  (div_valid[k]),
            .in_beat   (div_beat[k]),
            .out_valid (div_valid[k+1]),
            .out_beat  (div_beat[k+1])
        );
    end

    // Matrix products
    div_beat_t                  last_beat;
    logic signed [X_BITS-1:0]   x_val     [LANES];
    logic signed [PROD_BITS-1:0] prod_next [3][3];
    logic signed [PROD_BITS-1:0] prod_reg  [3][3];
    logic                       p_valid_reg;
    logic                       p_kind_reg;

    assign last_beat = div_beat[DIV_STEPS];

    always_comb
    begin
        for (int j = 0; j < LANES; j++)
        begin
            if (last_beat.kind == KIND_INV && j != 0)
            begin
                x_val[j] = {last_beat.w[j][CHANNEL_BITS-1], last_beat.w[j][CHANNEL_BITS-1:0]};
            end
            else
            begin
                x_val[j] = {1'b0, last_beat.w[j][CHANNEL_BITS-1:0]};
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[i][j] = PROD_BITS'(x_val[j]) * PROD_BITS'(COEF[last_beat.kind][i][j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= div_valid[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_kind_reg <= last_beat.kind;
            prod_reg   <= prod_next;
        end
    end

    // Row sums
    logic signed [SUM_BITS-1:0] sum_reg [3];
    logic                       s_valid_reg;
    logic                       s_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_kind_reg <= p_kind_reg;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= SUM_BITS'(prod_reg[i][0]) + SUM_BITS'(prod_reg[i][1])
                            + SUM_BITS'(prod_reg[i][2]);
            end
        end
    end

    // Forward rounding; inverse range split into negative, at least 1.0, fraction
    logic signed [SUM_BITS-1:0]  fwd_round [3];
    logic [CHANNEL_BITS-1:0]     q_fwd_reg  [3];
    logic                        q_neg_reg  [3];
    logic                        q_big_reg  [3];
    logic [INV_SHIFT-1:0]        q_frac_reg [3];
    logic                        q_valid_reg;
    logic                        q_kind_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fwd_round[i] = sum_reg[i] + FWD_HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            q_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_kind_reg <= s_kind_reg;
            for (int i = 0; i < 3; i++)
            begin
                q_fwd_reg[i]  <= fwd_round[i][COEF_BITS+CHANNEL_BITS-1:COEF_BITS];
                q_neg_reg[i]  <= sum_reg[i][SUM_BITS-1];
                q_big_reg[i]  <= !sum_reg[i][SUM_BITS-1]
                              && (sum_reg[i][SUM_BITS-2:INV_SHIFT] != '0);
                q_frac_reg[i] <= sum_reg[i][INV_SHIFT-1:0];
            end
        end
    end

    // Inverse: fraction times full scale
    logic [INV_PROD_BITS-1:0] m_prod_reg [3];
    logic [CHANNEL_BITS-1:0]  m_fwd_reg  [3];
    logic                     m_neg_reg  [3];
    logic                     m_big_reg  [3];
    logic                     m_valid_reg;
    logic                     m_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_kind_reg <= q_kind_reg;
            for (int i = 0; i < 3; i++)
            begin
                m_prod_reg[i] <= INV_PROD_BITS'(q_frac_reg[i]) * INV_PROD_BITS'(scale_reg);
                m_fwd_reg[i]  <= q_fwd_reg[i];
                m_neg_reg[i]  <= q_neg_reg[i];
                m_big_reg[i]  <= q_big_reg[i];
            end
        end
    end

    // Output stage: round, clamp to 0..m, zero the unused direction
    logic [INV_PROD_BITS:0]  inv_round [3];
    logic [CHANNEL_BITS:0]   inv_ch    [3];
    logic [CHANNEL_BITS-1:0] inv_clamp [3];
    pix_out_t                dst_data_reg;
    pix_out_t                dst_data_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            inv_round[i] = {1'b0, m_prod_reg[i]} + INV_HALF;
            inv_ch[i]    = inv_round[i][INV_PROD_BITS:INV_SHIFT];
            if (m_neg_reg[i])
            begin
                inv_clamp[i] = '0;
            end
            else if (m_big_reg[i] || inv_ch[i] > {1'b0, scale_reg})
            begin
                inv_clamp[i] = scale_reg;
            end
            else
            begin
                inv_clamp[i] = inv_ch[i][CHANNEL_BITS-1:0];
            end
        end
        dst_data_next = '0;
        if (m_kind_reg == KIND_FWD)
        begin
            dst_data_next.luma_out      = m_fwd_reg[0];
            dst_data_next.blue_diff_out = m_fwd_reg[1];
            dst_data_next.red_diff_out  = m_fwd_reg[2];
        end
        else
        begin
            dst_data_next.red_out   = inv_clamp[0];
            dst_data_next.green_out = inv_clamp[1];
            dst_data_next.blue_out  = inv_clamp[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dst_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dst_data_reg <= dst_data_next;
        end
    end

    assign dst_data = dst_data_reg;

    // Checks
    a_stall_only_on_held_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        src_stall |-> dst_valid)
        else $error("src_stall raised without a held result");

    a_accept_lands_in_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        src_valid && !src_stall |=> in_valid_reg)
        else $error("accepted beat missing from entry stage");

    a_result_from_last_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(dst_valid) |-> $past(m_valid_reg))
        else $error("result appeared without a beat in the last stage");

    a_one_direction_only: assert property (
        @(posedge clk) disable iff (!rst_n)
        dst_valid && (dst_data.red_out != '0 || dst_data.green_out != '0
                      || dst_data.blue_out != '0)
        |-> dst_data.luma_out == '0 && dst_data.blue_diff_out == '0
            && dst_data.red_diff_out == '0)
        else $error("both directions carry nonzero results");

endmodule

[rtl/core/rgbyp_div_stage.sv]
module rgbyp_div_stage (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic [rgbyp_pkg::CHANNEL_BITS-1:0] scale,
    input  logic                               in_valid,
    input  rgbyp_pkg::div_beat_t               in_beat,
    output logic                               out_valid,
    output rgbyp_pkg::div_beat_t               out_beat
);
    import rgbyp_pkg::*;

    logic      valid_reg;
    div_beat_t beat_reg;
    div_beat_t beat_next;
    logic [DIV_W:0]        shifted [LANES];
    logic [CHANNEL_BITS:0] hi      [LANES];

    // Forward restoring step per lane: shift in a dividend bit, subtract on fit
    always_comb
    begin
        beat_next = in_beat;
        for (int l = 0; l < LANES; l++)
        begin
            shifted[l] = {in_beat.w[l], 1'b0};
            hi[l]      = shifted[l][DIV_W:DIV_W-CHANNEL_BITS];
            if (in_beat.kind == KIND_FWD)
            begin
                if (hi[l] >= {1'b0, scale})
                begin
                    shifted[l][DIV_W:DIV_W-CHANNEL_BITS] = hi[l] - {1'b0, scale};
                    shifted[l][0] = 1'b1;
                end
                beat_next.w[l] = shifted[l][DIV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

[bench/rgb_ypbpr_color_convert_test.sv]
module rgb_ypbpr_color_convert_test;

    import rgbyp_pkg::*;

    // Q.16 BT.601 matrix entries, forward then inverse
    localparam longint KY_R   = 19595;
    localparam longint KY_G   = 38470;
    localparam longint KY_B   = 7471;
    localparam longint KPB_R  = 11058;
    localparam longint KPB_G  = 21710;
    localparam longint KHALF  = 32768;
    localparam longint KPR_G  = 27439;
    localparam longint KPR_B  = 5329;
    localparam longint KR_PR  = 91881;
    localparam longint KG_PB  = 22553;
    localparam longint KG_PR  = 46802;
    localparam longint KB_PB  = 116130;
    localparam longint ROUND_Q16 = 32768;

    localparam int CHOKE_CYCLES = 64;
    localparam int DRAIN_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_stall;
    pix_in_t     src_data = '0;
    logic        dst_valid;
    logic        dst_stall = 1'b0;
    pix_out_t    dst_data;
    logic        cfg_wen = 1'b0;
    logic [15:0] cfg_wdata = '0;

    // Full-scale value as the block should hold it
    logic [15:0] scale_reg = SCALE_RESET;

    pix_in_t  pending_pixels[$];
    pix_out_t predicted_pixels[$];

    int src_gap_max = 0;
    int dst_gap_max = 0;
    int src_wait = 0;
    int dst_hold = 0;
    int choke_req = 0;
    int choke_seen = 0;
    int errors = 0;

    rgb_ypbpr_color_convert u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Channel over full scale -> Q1.15 fraction, rounded half up
    function automatic longint to_fraction(input logic [15:0] chan, input longint m);
        longint v;
        v = longint'(chan);
        if (v > m)
            v = m;
        return ((v <<< 15) + (m >>> 1)) / m;
    endfunction

    // Q.31 fraction times full scale, rounded half up, clamped to 0..m
    function automatic logic [15:0] to_channel(input longint f, input longint m);
        longint t;
        t = f * m + (longint'(1) <<< 30);
        if (t < 0)
            return 16'(0);
        t = t >>> 31;
        if (t > m)
            t = m;
        return 16'(t);
    endfunction

    function automatic pix_out_t convert_pixel(input pix_in_t p, input logic [15:0] scale);
        longint m, fr, fg, fb, y, pb, pr;
        pix_out_t o;
        o = '0;
        m = (scale == 0) ? 1 : longint'(scale);
        if (p.kind == KIND_FWD)
        begin
            fr = to_fraction(p.red, m);
            fg = to_fraction(p.green, m);
            fb = to_fraction(p.blue, m);
            // arithmetic shift gives floor, so ties round up for negatives too
            y  = (KY_R * fr + KY_G * fg + KY_B * fb + ROUND_Q16) >>> 16;
            pb = (-KPB_R * fr - KPB_G * fg + KHALF * fb + ROUND_Q16) >>> 16;
            pr = (KHALF * fr - KPR_G * fg - KPR_B * fb + ROUND_Q16) >>> 16;
            o.luma_out      = 16'(y);
            o.blue_diff_out = 16'(pb);
            o.red_diff_out  = 16'(pr);
        end
        else
        begin
            y  = longint'(p.luma) <<< 16;
            pb = $signed(p.blue_diff);
            pr = $signed(p.red_diff);
            o.red_out   = to_channel(y + KR_PR * pr, m);
            o.green_out = to_channel(y - KG_PB * pb - KG_PR * pr, m);
            o.blue_out  = to_channel(y + KB_PB * pb, m);
        end
        return o;
    endfunction

    function automatic logic [15:0] random_channel(input logic [15:0] scale);
        int m;
        m = (scale == 0) ? 1 : scale;
        case ($urandom_range(0, 9))
            0: return 16'(0);
            1: return 16'(m);
            2: return 16'($urandom);
            3: return 16'(m + $urandom_range(0, 3));
            default: return 16'($urandom_range(0, m));
        endcase
    endfunction

    function automatic logic [15:0] random_diff();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic pix_in_t random_pixel(input logic [15:0] scale);
        pix_in_t p;
        p.kind      = $urandom_range(0, 1) ? KIND_INV : KIND_FWD;
        p.red       = random_channel(scale);
        p.green     = random_channel(scale);
        p.blue      = random_channel(scale);
        p.luma      = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 32768));
        p.blue_diff = random_diff();
        p.red_diff  = random_diff();
        return p;
    endfunction

    task automatic queue_pixel(input logic kind, input int r, input int g, input int b,
                               input int y, input int pb, input int pr);
        pix_in_t p;
        p.kind      = kind;
        p.red       = 16'(r);
        p.green     = 16'(g);
        p.blue      = 16'(b);
        p.luma      = 16'(y);
        p.blue_diff = 16'(pb);
        p.red_diff  = 16'(pr);
        pending_pixels.push_back(p);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Wait until every queued beat went in and every result came out
    task automatic wait_drained();
        @(negedge clk);
        while (pending_pixels.size() != 0 || src_valid || predicted_pixels.size() != 0)
            @(negedge clk);
    endtask

    // Only called with the pipeline empty
    task automatic write_scale(input logic [15:0] value);
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        scale_reg = value;
    endtask

    task automatic run_phase(input logic [15:0] scale, input int count, input int sgap,
                             input int dgap, input bit choke);
        write_scale(scale);
        repeat (4) @(posedge clk);
        @(negedge clk);
        src_gap_max = sgap;
        dst_gap_max = dgap;
        repeat (count) pending_pixels.push_back(random_pixel(scale));
        if (choke)
            choke_req++;
        wait_drained();
    endtask

    // Source side: present queued beats, random gap after each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_data  <= '0;
            src_wait  <= 0;
        end
        else
        begin
            if (src_valid && !src_stall)
                predicted_pixels.push_back(convert_pixel(src_data, scale_reg));
            if (!src_valid || !src_stall)
            begin
                if (src_wait != 0)
                begin
                    src_valid <= 1'b0;
                    src_wait  <= src_wait - 1;
                end
                else if (pending_pixels.size() != 0)
                begin
                    src_valid <= 1'b1;
                    src_data  <= pending_pixels.pop_front();
                    src_wait  <= $urandom_range(0, src_gap_max);
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    // Result side: check each beat, then hold dst_stall for a random hold-off
    always @(posedge clk or negedge rst_n)
    begin : result_side
        int hold;
        pix_out_t want;
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
            dst_hold  <= 0;
        end
        else
        begin
            hold = dst_hold;
            if (dst_valid && !dst_stall)
            begin
                if (predicted_pixels.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, dst_data);
                    errors++;
                end
                else
                begin
                    want = predicted_pixels.pop_front();
                    check_field("luma_out", want.luma_out, dst_data.luma_out);
                    check_field("blue_diff_out", want.blue_diff_out, dst_data.blue_diff_out);
                    check_field("red_diff_out", want.red_diff_out, dst_data.red_diff_out);
                    check_field("red_out", want.red_out, dst_data.red_out);
                    check_field("green_out", want.green_out, dst_data.green_out);
                    check_field("blue_out", want.blue_out, dst_data.blue_out);
                end
                hold = $urandom_range(0, dst_gap_max);
            end
            else if (hold != 0)
                hold--;
            // long hold-off so the pipeline backs up into src_stall
            if (choke_req != choke_seen)
            begin
                hold = CHOKE_CYCLES;
                choke_seen <= choke_req;
            end
            dst_hold  <= hold;
            dst_stall <= (hold != 0);
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        src_gap_max = 7;
        dst_gap_max = 7;

        // Directed beats at the reset full scale of 255
        queue_pixel(KIND_FWD, 0, 0, 0, 0, 0, 0);
        queue_pixel(KIND_FWD, 255, 255, 255, 0, 0, 0);
        queue_pixel(KIND_FWD, 255, 0, 0, 0, 0, 0);
        queue_pixel(KIND_FWD, 0, 255, 0, 0, 0, 0);
        queue_pixel(KIND_FWD, 0, 0, 255, 0, 0, 0);
        queue_pixel(KIND_FWD, 65535, 65535, 65535, 65535, -1, -1);
        queue_pixel(KIND_FWD, 256, 128, 1, 32768, 16384, -16384);
        queue_pixel(KIND_FWD, 128, 128, 128, 0, 0, 0);
        queue_pixel(KIND_FWD, 16'hAAAA, 16'h5555, 16'h00FF, 16'h5555, 16'hAAAA, 16'h5555);
        queue_pixel(KIND_INV, 0, 0, 0, 0, 0, 0);
        queue_pixel(KIND_INV, 0, 0, 0, 32768, 0, 0);
        queue_pixel(KIND_INV, 0, 0, 0, 16384, 16384, 0);
        queue_pixel(KIND_INV, 0, 0, 0, 16384, -16384, 0);
        queue_pixel(KIND_INV, 0, 0, 0, 16384, 0, 16384);
        queue_pixel(KIND_INV, 0, 0, 0, 16384, 0, -16384);
        queue_pixel(KIND_INV, 0, 0, 0, 32768, 16384, 16384);
        queue_pixel(KIND_INV, 0, 0, 0, 0, -16384, -16384);
        // inverse inputs out of range: still clamped to 0..full scale
        queue_pixel(KIND_INV, 0, 0, 0, 65535, 32767, 32767);
        queue_pixel(KIND_INV, 0, 0, 0, 0, -32768, -32768);
        queue_pixel(KIND_INV, 65535, 65535, 65535, 65535, -32768, 32767);
        queue_pixel(KIND_INV, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
        wait_drained();

        // Random beats across full-scale settings; zero acts as one
        run_phase(16'd0, 100, 7, 7, 1'b0);
        run_phase(16'd1, 100, 0, 7, 1'b0);
        run_phase(16'hFFFF, 100, 7, 0, 1'b0);
        run_phase(16'd1023, 150, 0, 0, 1'b1);
        run_phase(16'($urandom_range(2, 65534)), 100, 7, 7, 1'b0);
        run_phase(16'd255, 150, 3, 5, 1'b0);

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && predicted_pixels.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/rgbyp_pkg.sv
rtl/core/rgbyp_div_stage.sv
rtl/core/rgb_ypbpr_color_convert.sv
bench/rgb_ypbpr_color_convert_test.sv
